// File: rtl/button_click_long_press_detector_macros.svh
// assertion macros for the button click and long press detector
`ifndef BUTTON_CLICK_LONG_PRESS_DETECTOR_MACROS_SVH
`define BUTTON_CLICK_LONG_PRESS_DETECTOR_MACROS_SVH
`ifndef SYNTHESIS
`define BCLP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bclp assertion failed");
`define BCLP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bclp assertion failed");
`else
`define BCLP_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define BCLP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/bclp_pkg.sv
// shared types and constants of the button click and long press detector
package bclp_pkg;

   localparam int BUTTONS    = 8;
   localparam int SLOT_W     = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
   localparam int TICK_W     = 32;
   localparam int CNT_W      = 8;
   localparam int IDX_W      = 3;
   localparam int CLICK_W    = 2;
   localparam int BCOUNT_W   = 4;
   localparam int DEB_W      = 20;
   localparam int LONG_W     = 22;
   localparam int TPU_W      = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int unsigned CLICK_GAP_US      = 10000;
   localparam int unsigned REPORT_GAP_FACTOR = 10;
   localparam int unsigned TIMEOUT_FACTOR    = 2;

   // operation codes
   localparam logic OP_POLL = 1'b0;
   localparam logic OP_EDGE = 1'b1;

   // click codes
   localparam logic [CLICK_W-1:0] CLICK_NONE   = 2'd0;
   localparam logic [CLICK_W-1:0] CLICK_SINGLE = 2'd1;
   localparam logic [CLICK_W-1:0] CLICK_DOUBLE = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PRESS_LEVEL    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTERRUPT_MASK = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BUTTON_COUNT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE_US    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_PRESS_US  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TICKS_PER_US   = 3'd5;

   // register reset values
   localparam logic              RST_PRESS_LEVEL  = 1'b1;
   localparam logic [IDX_W+4:0]  RST_INT_MASK     = '0;
   localparam logic [BCOUNT_W-1:0] RST_BCOUNT     = '0;
   localparam logic [DEB_W-1:0]  RST_DEBOUNCE    = DEB_W'(50000);
   localparam logic [LONG_W-1:0] RST_LONG        = LONG_W'(1000000);
   localparam logic [TPU_W-1:0]  RST_TPU         = TPU_W'(1);

   typedef struct packed {
      logic [TICK_W-1:0] first_tick;
      logic [TICK_W-1:0] last_tick;
      logic [CNT_W-1:0]  click_cnt;
   } btn_state_type;

   // thresholds in ticks
   typedef struct packed {
      logic [TICK_W-1:0] debounce;
      logic [TICK_W-1:0] long_press;
      logic [TICK_W-1:0] timeout;
      logic [TICK_W-1:0] click_gap;
      logic [TICK_W-1:0] report_gap;
   } thresh_type;

   typedef struct packed {
      logic in_range;
      logic edge_mode;
      logic press_level;
   } ctl_type;

endpackage

// File: rtl/bclp_eval.sv
// per-item classification of one button: recording, debounce, long press, clicks, timeout
module bclp_eval import bclp_pkg::*; (
   input  ctl_type             ctl,
   input  thresh_type          thr,
   input  logic                op,
   input  logic                pin_level,
   input  logic [TICK_W-1:0]   now_tick,
   input  btn_state_type       cur,
   output btn_state_type       nxt,
   output logic                long_press,
   output logic [CLICK_W-1:0]  click_event
);

   logic              record;
   logic              poll;
   logic [TICK_W-1:0] first1;
   logic [TICK_W-1:0] last1;
   logic [TICK_W-1:0] span_fn;
   logic [TICK_W-1:0] span_fl;
   logic [TICK_W-1:0] span_ln;
   logic              armed;
   logic              gap_hit;
   logic              report;
   logic              tmo_hit;
   logic [CNT_W-1:0]  count1;
   logic [TICK_W-1:0] first2;

   assign record = ctl.in_range &&
                   ((op == OP_EDGE && ctl.edge_mode) ||
                    (op == OP_POLL && !ctl.edge_mode && pin_level == ctl.press_level));
   assign poll   = ctl.in_range && op == OP_POLL;

   assign first1 = (record && cur.first_tick == '0) ? now_tick : cur.first_tick;
   assign last1  = (record && cur.first_tick != '0) ? now_tick : cur.last_tick;

   // elapsed times wrap modulo the tick width
   assign span_fn = now_tick - first1;
   assign span_fl = last1 - first1;
   assign span_ln = now_tick - last1;

   assign armed      = poll && first1 != '0 && last1 != '0 && span_fn > thr.debounce;
   assign long_press = armed && span_fl > thr.long_press;
   assign gap_hit    = armed && !long_press && span_ln > thr.click_gap;
   assign count1     = gap_hit ? cur.click_cnt + CNT_W'(1) : cur.click_cnt;
   assign report     = poll && span_ln > thr.report_gap && count1 != '0 && last1 != '0;
   assign first2     = (long_press || gap_hit) ? '0 : first1;
   // an empty first tick stays empty, so the timeout can use the span from first1
   assign tmo_hit    = poll && span_fn > thr.timeout;

   always_comb begin
      click_event = CLICK_NONE;
      if (report) begin
         if (count1 == CNT_W'(1)) begin
            click_event = CLICK_SINGLE;
         end else if (count1 == CNT_W'(2)) begin
            click_event = CLICK_DOUBLE;
         end
      end
   end

   always_comb begin
      nxt.first_tick = tmo_hit ? '0 : first2;
      nxt.last_tick  = last1;
      nxt.click_cnt  = report ? '0 : count1;
   end

endmodule

// File: rtl/button_click_long_press_detector.sv
// button click and long press detector top level
// an accepted item is registered in the input stage, then in the result stage once it is free
// throughput: one item per cycle while the result side takes them; per-button state is read,
// updated and written back as the item leaves the input stage, so one button may be hit
// back to back; a configuration write holds off new items while the tick thresholds settle
// reset clears all button state, empties both stages and restores register defaults
module button_click_long_press_detector import bclp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_op,
   input  logic [IDX_W-1:0]      req_button_index,
   input  logic                  req_pin_level,
   input  logic [TICK_W-1:0]     req_now_tick,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [IDX_W-1:0]      rsp_event_button,
   output logic                  rsp_long_press,
   output logic [CLICK_W-1:0]    rsp_click_event,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

`include "button_click_long_press_detector_macros.svh"

   // configuration registers
   logic                press_lvl_ff;
   logic [7:0]          int_mask_ff;
   logic [BCOUNT_W-1:0] bcount_ff;
   logic [DEB_W-1:0]    debounce_ff;
   logic [LONG_W-1:0]   long_ff;
   logic [TPU_W-1:0]    tpu_ff;
   logic                settle_ff;
   thresh_type          thr_ff;
   thresh_type          thr_in;
   logic [TICK_W-1:0]   long_prod;
   logic                csr_write;

   // input stage
   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic                s1_op_ff;
   logic [IDX_W-1:0]    s1_idx_ff;
   logic                s1_level_ff;
   logic [TICK_W-1:0]   s1_now_ff;

   // result stage
   logic                rsp_valid_ff;
   logic [IDX_W-1:0]    rsp_button_ff;
   logic                rsp_long_ff;
   logic [CLICK_W-1:0]  rsp_click_ff;

   btn_state_type       state_ff [BUTTONS];
   btn_state_type       cur_state;
   btn_state_type       nxt_state;
   logic [SLOT_W-1:0]   slot;
   ctl_type             ctl;
   logic                out_free;
   logic                advance;
   logic                accept;
   logic                ev_long;
   logic [CLICK_W-1:0]  ev_click;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         press_lvl_ff <= RST_PRESS_LEVEL;
         int_mask_ff  <= RST_INT_MASK;
         bcount_ff    <= RST_BCOUNT;
         debounce_ff  <= RST_DEBOUNCE;
         long_ff      <= RST_LONG;
         tpu_ff       <= RST_TPU;
         settle_ff    <= 1'b0;
      end else begin
         settle_ff <= csr_write;
         if (csr_write) begin
            case (csr_index)
               REG_PRESS_LEVEL:    press_lvl_ff <= csr_wdata[0];
               REG_INTERRUPT_MASK: int_mask_ff  <= csr_wdata[7:0];
               REG_BUTTON_COUNT:   bcount_ff    <= csr_wdata[BCOUNT_W-1:0];
               REG_DEBOUNCE_US:    debounce_ff  <= csr_wdata[DEB_W-1:0];
               REG_LONG_PRESS_US:  long_ff      <= csr_wdata[LONG_W-1:0];
               REG_TICKS_PER_US:   tpu_ff       <= csr_wdata[TPU_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // thresholds scaled to ticks, registered behind the configuration registers
   assign long_prod = TICK_W'(long_ff) * TICK_W'(tpu_ff);

   always_comb begin
      thr_in.debounce   = TICK_W'(debounce_ff) * TICK_W'(tpu_ff);
      thr_in.long_press = long_prod;
      thr_in.timeout    = TICK_W'(long_prod * TIMEOUT_FACTOR);
      thr_in.click_gap  = TICK_W'(CLICK_GAP_US) * TICK_W'(tpu_ff);
      thr_in.report_gap = TICK_W'(CLICK_GAP_US * REPORT_GAP_FACTOR) * TICK_W'(tpu_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff.debounce   <= TICK_W'(50000);
         thr_ff.long_press <= TICK_W'(1000000);
         thr_ff.timeout    <= TICK_W'(2000000);
         thr_ff.click_gap  <= TICK_W'(CLICK_GAP_US);
         thr_ff.report_gap <= TICK_W'(CLICK_GAP_US * REPORT_GAP_FACTOR);
      end else begin
         thr_ff <= thr_in;
      end
   end

   // handshake and stage flow
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign advance     = s1_valid_ff && out_free;
   assign req_stall   = (s1_valid_ff && !out_free) || settle_ff;
   assign accept      = req_valid && !req_stall;
   assign s1_valid_in = accept || (s1_valid_ff && !out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= req_op;
         s1_idx_ff   <= req_button_index;
         s1_level_ff <= req_pin_level;
         s1_now_ff   <= req_now_tick;
      end
   end

   assign slot            = SLOT_W'(s1_idx_ff);
   assign cur_state       = state_ff[slot];
   assign ctl.in_range    = (BCOUNT_W'(s1_idx_ff) < bcount_ff) && (int'(s1_idx_ff) < BUTTONS);
   assign ctl.edge_mode   = int_mask_ff[s1_idx_ff];
   assign ctl.press_level = press_lvl_ff;

   bclp_eval u_eval (
      .ctl         (ctl),
      .thr         (thr_ff),
      .op          (s1_op_ff),
      .pin_level   (s1_level_ff),
      .now_tick    (s1_now_ff),
      .cur         (cur_state),
      .nxt         (nxt_state),
      .long_press  (ev_long),
      .click_event (ev_click)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BUTTONS; i++) begin
            state_ff[i] <= '0;
         end
      end else if (advance && ctl.in_range) begin
         state_ff[slot] <= nxt_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_button_ff <= s1_idx_ff;
         rsp_long_ff   <= ev_long;
         rsp_click_ff  <= ev_click;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_button = rsp_button_ff;
   assign rsp_long_press   = rsp_long_ff;
   assign rsp_click_event  = rsp_click_ff;

   `BCLP_ASSERT_NEXT(a_advance_loads, clock, reset, advance, rsp_valid_ff)
   `BCLP_ASSERT_NEXT(a_long_clears_first, clock, reset, advance && ev_long,
      state_ff[$past(slot)].first_tick == '0)
   `BCLP_ASSERT_NEXT(a_idle_no_event, clock, reset, advance && bcount_ff == '0,
      !rsp_long_ff && rsp_click_ff == CLICK_NONE)
   `BCLP_ASSERT_SAME(a_click_code, clock, reset, rsp_valid_ff,
      rsp_click_ff == CLICK_NONE || rsp_click_ff == CLICK_SINGLE ||
      rsp_click_ff == CLICK_DOUBLE)

endmodule

// File: tb/sv/bclp_report_checker.sv
// scoreboard that predicts and checks every press report of the detector
module bclp_report_checker import bclp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  req_op,
   input  logic [IDX_W-1:0]      req_button_index,
   input  logic                  req_pin_level,
   input  logic [TICK_W-1:0]     req_now_tick,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [IDX_W-1:0]      rsp_event_button,
   input  logic                  rsp_long_press,
   input  logic [CLICK_W-1:0]    rsp_click_event,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    pending,
   output int                    errors
);

   typedef struct packed {
      logic [IDX_W-1:0]   button;
      logic               long_press;
      logic [CLICK_W-1:0] click;
   } press_report_type;

   // shadow copy of the registers
   logic                lvl_pressed;
   logic [BUTTONS-1:0]  edge_mask;
   logic [BCOUNT_W-1:0] buttons_used;
   logic [DEB_W-1:0]    debounce_cfg;
   logic [LONG_W-1:0]   long_cfg;
   logic [TPU_W-1:0]    tick_scale;

   // shadow copy of the per-button state
   logic [TICK_W-1:0] press_start  [BUTTONS];
   logic [TICK_W-1:0] press_latest [BUTTONS];
   logic [CNT_W-1:0]  click_tally  [BUTTONS];

   press_report_type expected_reports [$];
   press_report_type want;

   function automatic logic [63:0] tick_span(logic [TICK_W-1:0] from_t,
                                             logic [TICK_W-1:0] to_t);
      logic [TICK_W-1:0] d;
      d = to_t - from_t;
      return 64'(d);
   endfunction

   function automatic void mark_press(logic [IDX_W-1:0] btn, logic [TICK_W-1:0] now);
      if (press_start[btn] == '0) begin
         press_start[btn] = now;
      end else begin
         press_latest[btn] = now;
      end
   endfunction

   function automatic press_report_type classify_press(logic op, logic [IDX_W-1:0] btn,
                                                       logic lvl, logic [TICK_W-1:0] now);
      press_report_type r;
      logic             edge_btn;
      logic [63:0]      scale;
      r.button     = btn;
      r.long_press = 1'b0;
      r.click      = CLICK_NONE;
      scale        = 64'(tick_scale);
      if (buttons_used == '0 || {1'b0, btn} >= buttons_used) begin
         return r;
      end
      edge_btn = edge_mask[btn];
      if (op == OP_EDGE) begin
         if (edge_btn) begin
            mark_press(btn, now);
         end
         return r;
      end
      if (lvl == lvl_pressed && !edge_btn) begin
         mark_press(btn, now);
      end
      if (press_start[btn] != '0 && press_latest[btn] != '0 &&
          tick_span(press_start[btn], now) > 64'(debounce_cfg) * scale) begin
         if (tick_span(press_start[btn], press_latest[btn]) > 64'(long_cfg) * scale) begin
            r.long_press     = 1'b1;
            press_start[btn] = '0;
         end else if (tick_span(press_latest[btn], now) > 64'(CLICK_GAP_US) * scale) begin
            click_tally[btn] = click_tally[btn] + CNT_W'(1);
            press_start[btn] = '0;
         end
      end
      // quiet long enough after the last press: report the tally and drop it
      if (tick_span(press_latest[btn], now) >
             64'(CLICK_GAP_US) * 64'(REPORT_GAP_FACTOR) * scale &&
          click_tally[btn] != '0 && press_latest[btn] != '0) begin
         if (click_tally[btn] == CNT_W'(1)) begin
            r.click = CLICK_SINGLE;
         end else if (click_tally[btn] == CNT_W'(2)) begin
            r.click = CLICK_DOUBLE;
         end
         click_tally[btn] = '0;
      end
      if (tick_span(press_start[btn], now) > 64'(long_cfg) * 64'(TIMEOUT_FACTOR) * scale) begin
         press_start[btn] = '0;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         lvl_pressed  = RST_PRESS_LEVEL;
         edge_mask    = RST_INT_MASK;
         buttons_used = RST_BCOUNT;
         debounce_cfg = RST_DEBOUNCE;
         long_cfg     = RST_LONG;
         tick_scale   = RST_TPU;
         for (int i = 0; i < BUTTONS; i++) begin
            press_start[i]  = '0;
            press_latest[i] = '0;
            click_tally[i]  = '0;
         end
         expected_reports.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               $error("report item arrived with nothing expected");
               errors = errors + 1;
            end else begin
               want = expected_reports.pop_front();
               if (rsp_event_button !== want.button) begin
                  $error("event_button: expected %0d, actual %0d",
                         want.button, rsp_event_button);
                  errors = errors + 1;
               end
               if (rsp_long_press !== want.long_press) begin
                  $error("long_press: expected %0d, actual %0d",
                         want.long_press, rsp_long_press);
                  errors = errors + 1;
               end
               if (rsp_click_event !== want.click) begin
                  $error("click_event: expected %0d, actual %0d",
                         want.click, rsp_click_event);
                  errors = errors + 1;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_PRESS_LEVEL:    lvl_pressed  = csr_wdata[0];
               REG_INTERRUPT_MASK: edge_mask    = csr_wdata[BUTTONS-1:0];
               REG_BUTTON_COUNT:   buttons_used = csr_wdata[BCOUNT_W-1:0];
               REG_DEBOUNCE_US:    debounce_cfg = csr_wdata[DEB_W-1:0];
               REG_LONG_PRESS_US:  long_cfg     = csr_wdata[LONG_W-1:0];
               REG_TICKS_PER_US:   tick_scale   = csr_wdata[TPU_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_reports.push_back(classify_press(req_op, req_button_index,
                                                      req_pin_level, req_now_tick));
         end
      end
      pending = expected_reports.size();
   end

endmodule

// File: tb/sv/tb_button_click_long_press_detector.sv
// testbench top: clock, reset, press gestures, register phases and the verdict
module tb_button_click_long_press_detector;
   import bclp_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASES          = 10;
   localparam int PHASE_ITEMS     = 20;
   localparam int WRAP_CLICKS     = 258;

   // decoded to nothing by the block
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = 3'd7;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_op           = OP_POLL;
   logic [IDX_W-1:0]      req_button_index = '0;
   logic                  req_pin_level    = 1'b0;
   logic [TICK_W-1:0]     req_now_tick     = '0;
   logic                  rsp_stall        = 1'b0;
   logic                  csr_valid        = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index        = '0;
   logic [CSR_DATA_W-1:0] csr_wdata        = '0;

   logic                  req_stall;
   logic                  rsp_valid;
   logic [IDX_W-1:0]      rsp_event_button;
   logic                  rsp_long_press;
   logic [CLICK_W-1:0]    rsp_click_event;
   logic                  csr_ready;

   int pending;
   int errors;
   int snd_idle_pct = 38;
   int rcv_idle_pct = 88;
   int hold_cycles  = 0;
   int cycle_count  = 0;
   int live_items   = 0;
   int sent_items   = 0;
   int phase_start;

   // mirror of what has been written, used to shape gestures
   logic                cur_pressed_lvl = RST_PRESS_LEVEL;
   logic [BUTTONS-1:0]  cur_mask        = '0;
   logic [BCOUNT_W-1:0] cur_count       = '0;
   logic                spare_pick      = 1'b0;
   logic [63:0]         deb_t, long_t, gap_t, rep_t, tmo_t;
   logic [TICK_W-1:0]   tick_now;

   button_click_long_press_detector u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_button_index (req_button_index),
      .req_pin_level    (req_pin_level),
      .req_now_tick     (req_now_tick),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_button (rsp_event_button),
      .rsp_long_press   (rsp_long_press),
      .rsp_click_event  (rsp_click_event),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   bclp_report_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_button_index (req_button_index),
      .req_pin_level    (req_pin_level),
      .req_now_tick     (req_now_tick),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_button (rsp_event_button),
      .rsp_long_press   (rsp_long_press),
      .rsp_click_event  (rsp_click_event),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .pending          (pending),
      .errors           (errors)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_button_click_long_press_detector: FAIL");
         $finish;
      end
   end

   // result side: random stall, or a counted hold-off when one is requested
   always @(negedge clock) begin
      if (hold_cycles != 0) begin
         rsp_stall <= 1'b1;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
      end
   end

   task automatic push_item(logic op, logic [IDX_W-1:0] btn, logic lvl,
                            logic [TICK_W-1:0] now);
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_op           <= op;
      req_button_index <= btn;
      req_pin_level    <= lvl;
      req_now_tick     <= now;
      do @(posedge clock); while (req_stall);
      sent_items++;
      if ({1'b0, btn} < cur_count && !(op == OP_EDGE && !cur_mask[btn])) begin
         live_items++;
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // bits above the register width must be dropped by the block
   function automatic logic [CSR_DATA_W-1:0] with_junk(logic [CSR_DATA_W-1:0] v, int w);
      if ($urandom_range(0, 1) != 0) begin
         return v | (CSR_DATA_W'($urandom) << w);
      end
      return v;
   endfunction

   task automatic set_config(logic ah, logic [BUTTONS-1:0] mask, logic [BCOUNT_W-1:0] cnt,
                             logic [DEB_W-1:0] deb, logic [LONG_W-1:0] lng,
                             logic [TPU_W-1:0] tpu);
      wait_drained();
      csr_write(spare_pick ? REG_SPARE_B : REG_SPARE_A, CSR_DATA_W'($urandom));
      spare_pick = ~spare_pick;
      csr_write(REG_PRESS_LEVEL, with_junk(CSR_DATA_W'(ah), 1));
      csr_write(REG_INTERRUPT_MASK, with_junk(CSR_DATA_W'(mask), BUTTONS));
      csr_write(REG_BUTTON_COUNT, with_junk(CSR_DATA_W'(cnt), BCOUNT_W));
      csr_write(REG_DEBOUNCE_US, with_junk(CSR_DATA_W'(deb), DEB_W));
      csr_write(REG_LONG_PRESS_US, with_junk(CSR_DATA_W'(lng), LONG_W));
      csr_write(REG_TICKS_PER_US, with_junk(CSR_DATA_W'(tpu), TPU_W));
      @(negedge clock);
      csr_valid <= 1'b0;
      cur_pressed_lvl = ah;
      cur_mask        = mask;
      cur_count       = cnt;
      deb_t           = 64'(deb) * 64'(tpu);
      long_t          = 64'(lng) * 64'(tpu);
      gap_t           = 64'(CLICK_GAP_US) * 64'(tpu);
      rep_t           = gap_t * 64'(REPORT_GAP_FACTOR);
      tmo_t           = long_t * 64'(TIMEOUT_FACTOR);
   endtask

   task automatic advance(logic [63:0] step);
      tick_now = tick_now + step[TICK_W-1:0];
   endtask

   // time step that is small, random, or lands on, just past or around one of the thresholds
   function automatic logic [63:0] pick_step();
      logic [63:0] base;
      case ($urandom_range(0, 7))
         0: return 64'($urandom_range(0, 3));
         1: base = gap_t;
         2: base = deb_t;
         3: base = long_t;
         4: base = rep_t;
         5: base = tmo_t;
         6: return 64'($urandom);
         default: return 64'($urandom_range(1, 32'(gap_t) + 1));
      endcase
      if ($urandom_range(0, 1) != 0) begin
         return base + 64'($urandom_range(0, 2)) - 64'd1;
      end
      return base * 64'($urandom_range(50, 150)) / 64'd100;
   endfunction

   task automatic press_sample(logic [IDX_W-1:0] btn);
      if (cur_mask[btn]) begin
         push_item(OP_EDGE, btn, 1'($urandom_range(0, 1)), tick_now);
      end else begin
         push_item(OP_POLL, btn, cur_pressed_lvl, tick_now);
      end
   endtask

   task automatic noise_item();
      push_item(1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, BUTTONS - 1)),
                1'($urandom_range(0, 1)), TICK_W'($urandom));
   endtask

   // one or more presses on a button, then a quiet poll so the tally is reported, and up to two noise items
   task automatic play_gesture();
      logic [IDX_W-1:0] btn;
      int               kind;
      int               presses;
      int               holds;
      logic [63:0]      hold_t;
      logic [63:0]      lo;
      logic [63:0]      hi;
      if (cur_count != 0 && $urandom_range(0, 9) != 0) begin
         btn = IDX_W'($urandom_range(0, int'(cur_count) - 1));
      end else begin
         btn = IDX_W'($urandom_range(0, BUTTONS - 1));
      end
      kind    = $urandom_range(0, 9);
      presses = (kind < 4) ? 1 : (kind < 7) ? 2 : (kind < 9) ? 3 : $urandom_range(1, 5);
      repeat (presses) begin
         if (kind == 0) begin
            hold_t = long_t + 64'd1 + 64'($urandom_range(0, 32'(long_t / 64'd2)));
         end else begin
            lo     = deb_t + 64'd1;
            hi     = (long_t > lo) ? long_t : lo;
            hold_t = lo + 64'($urandom_range(0, 32'(hi - lo)));
         end
         if ($urandom_range(0, 29) == 0) begin
            tick_now = '0;
         end
         press_sample(btn);
         holds = $urandom_range(1, 3);
         repeat (holds) begin
            if ($urandom_range(0, 6) == 0) begin
               advance(pick_step());
            end else begin
               advance(hold_t / 64'(holds));
            end
            press_sample(btn);
         end
         if ($urandom_range(0, 6) == 0) begin
            advance(pick_step());
         end else begin
            advance(gap_t + 64'd1 + 64'($urandom_range(0, 32'(gap_t * 64'd8))));
         end
         push_item(OP_POLL, btn, cur_mask[btn] ? 1'($urandom_range(0, 1)) : ~cur_pressed_lvl,
                   tick_now);
      end
      advance(rep_t + 64'd1 + 64'($urandom_range(0, 32'(rep_t / 64'd4))));
      push_item(OP_POLL, btn, ~cur_pressed_lvl, tick_now);
      repeat ($urandom_range(0, 2)) noise_item();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // nothing in use yet, so both are ignored
      push_item(OP_POLL, 3'd0, 1'b1, 32'd100);
      push_item(OP_EDGE, 3'd7, 1'b0, 32'hFFFF_FFFF);

      set_config(1'b1, 8'h0A, 4'd4, 20'd100, 22'd1000, 8'd1);
      // single click on a polled button
      push_item(OP_POLL, 3'd0, 1'b1, 32'd1000);
      push_item(OP_POLL, 3'd0, 1'b1, 32'd1500);
      push_item(OP_POLL, 3'd0, 1'b0, 32'd11501);
      push_item(OP_POLL, 3'd0, 1'b0, 32'd111502);
      // long press shows up while still held
      push_item(OP_POLL, 3'd2, 1'b1, 32'd200000);
      push_item(OP_POLL, 3'd2, 1'b1, 32'd201500);
      // double click from edge interrupts
      push_item(OP_EDGE, 3'd1, 1'b0, 32'd300000);
      push_item(OP_EDGE, 3'd1, 1'b1, 32'd300300);
      push_item(OP_POLL, 3'd1, 1'b0, 32'd310301);
      push_item(OP_EDGE, 3'd1, 1'b0, 32'd310400);
      push_item(OP_EDGE, 3'd1, 1'b0, 32'd310700);
      push_item(OP_POLL, 3'd1, 1'b1, 32'd320701);
      push_item(OP_POLL, 3'd1, 1'b0, 32'd420702);
      // edge on a polled button, then buttons past the count
      push_item(OP_EDGE, 3'd0, 1'b1, 32'd500000);
      push_item(OP_POLL, 3'd5, 1'b1, 32'd500001);
      push_item(OP_POLL, 3'd7, 1'b1, 32'hFFFF_FFFF);
      // a zero tick keeps the entry empty
      push_item(OP_POLL, 3'd0, 1'b1, 32'd0);
      push_item(OP_POLL, 3'd0, 1'b1, 32'hFFFF_FFFF);
      push_item(OP_POLL, 3'd0, 1'b0, 32'd5);

      for (int p = 0; p < PHASES; p++) begin
         if (p < 3) begin
            snd_idle_pct = 38;
            rcv_idle_pct = 88;
         end else if (p < 6) begin
            snd_idle_pct = 88;
            rcv_idle_pct = 38;
         end else begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
         end
         case (p)
            0: set_config(1'b1, 8'h00, 4'd8, 20'd0, 22'd0, 8'd1);
            1: set_config(1'b0, 8'hFF, 4'd8, 20'd1000000, 22'd4000000, 8'd255);
            2: set_config(1'b1, BUTTONS'($urandom), 4'd3, 20'd50000, 22'd1000000, 8'd1);
            3: set_config(1'($urandom_range(0, 1)), BUTTONS'($urandom), 4'd0,
                          DEB_W'($urandom_range(0, 60000)), LONG_W'($urandom_range(0, 2000000)),
                          TPU_W'($urandom_range(1, 255)));
            // zero scale makes every threshold zero
            4: set_config(1'($urandom_range(0, 1)), BUTTONS'($urandom), 4'd8, 20'd500,
                          22'd2000, 8'd0);
            default: set_config(1'($urandom_range(0, 1)), BUTTONS'($urandom),
                                BCOUNT_W'($urandom_range(1, 8)),
                                DEB_W'($urandom_range(0, 60000)),
                                LONG_W'($urandom_range(0, 2000000)),
                                TPU_W'($urandom_range(1, 255)));
         endcase
         if (p == 6) begin
            hold_cycles = HOLD_OFF_CYCLES;
         end
         tick_now    = TICK_W'($urandom);
         live_items  = 0;
         phase_start = sent_items;
         while (live_items < PHASE_ITEMS && sent_items - phase_start < 4 * PHASE_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
               noise_item();
            end else begin
               play_gesture();
            end
         end
      end

      // click tally runs past 255 and wraps; every press lands on the same tick so
      // the press span stays zero and each late release counts one click
      set_config(1'b1, 8'h00, 4'd1, 20'd0, 22'd0, 8'd1);
      tick_now = TICK_W'($urandom_range(1, 32'hF000_0000));
      push_item(OP_POLL, 3'd0, 1'b1, tick_now);
      push_item(OP_POLL, 3'd0, 1'b1, tick_now);
      repeat (WRAP_CLICKS) begin
         push_item(OP_POLL, 3'd0, 1'b1, tick_now);
         push_item(OP_POLL, 3'd0, 1'b0, tick_now + TICK_W'(gap_t + 64'd1));
      end
      advance(gap_t + rep_t + 64'd2);
      push_item(OP_POLL, 3'd0, 1'b0, tick_now);

      wait_drained();
      repeat (4) @(posedge clock);
      if (errors == 0) begin
         $display("tb_button_click_long_press_detector: PASS");
      end else begin
         $display("tb_button_click_long_press_detector: FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/bclp_pkg.sv
rtl/bclp_eval.sv
rtl/button_click_long_press_detector.sv
tb/sv/bclp_report_checker.sv
tb/sv/tb_button_click_long_press_detector.sv
